[rtl/acs_pkg.sv]
// Shared types and constants for the accumulator processor step core.
// Opcodes, mode codes, microcode steps and the control ROM.
// No dependencies.
`default_nettype none
package acs_pkg;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_EXEC    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic [7:0] OP_NOP = 8'h00;
   localparam logic [7:0] OP_HLT = 8'h01;
   localparam logic [7:0] OP_LDA = 8'h02;
   localparam logic [7:0] OP_ADD = 8'h03;
   localparam logic [7:0] OP_SUB = 8'h04;
   localparam logic [7:0] OP_JMP = 8'h06;
   localparam logic [7:0] OP_JPZ = 8'h07;
   localparam logic [7:0] OP_JPN = 8'h08;
   localparam logic [7:0] OP_JPC = 8'h09;

   localparam logic [15:0] STEP_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FETCH_OP,
      ST_FETCH_ARG,
      ST_EXEC,
      ST_RESTART,
      ST_EMIT
   } step_type;

   // sequencing: go to target, dispatch on accepted mode, or branch on a condition
   typedef enum logic [1:0] {
      SQ_GO,
      SQ_ACCEPT,
      SQ_HALTED,
      SQ_OUT_FREE
   } seq_type;

   typedef struct packed {
      seq_type  seq;
      step_type target;   // taken when condition true
      step_type alt;      // taken when condition false
      logic     rd_next;  // read address pc+1 instead of pc
      logic     latch_op;
      logic     mem_wr;
      logic     clr_regs;
      logic     exec;
      logic     emit;
   } ctrl_type;

   function automatic ctrl_type ucode(step_type s);
      ctrl_type c;
      c = '0;
      c.seq    = SQ_GO;
      c.target = ST_IDLE;
      c.alt    = ST_IDLE;
      case (s)
         ST_IDLE: begin
            c.seq = SQ_ACCEPT;
         end
         ST_LOAD: begin
            c.mem_wr = 1'b1;
            c.target = ST_EMIT;
         end
         ST_FETCH_OP: begin
            c.seq    = SQ_HALTED;
            c.target = ST_EMIT;
            c.alt    = ST_FETCH_ARG;
         end
         ST_FETCH_ARG: begin
            c.latch_op = 1'b1;
            c.rd_next  = 1'b1;
            c.target   = ST_EXEC;
         end
         ST_EXEC: begin
            c.exec   = 1'b1;
            c.target = ST_EMIT;
         end
         ST_RESTART: begin
            c.clr_regs = 1'b1;
            c.target   = ST_EMIT;
         end
         ST_EMIT: begin
            c.seq    = SQ_OUT_FREE;
            c.emit   = 1'b1;
            c.target = ST_IDLE;
            c.alt    = ST_EMIT;
         end
         default: begin
            c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/acs_if.sv]
// Handshake channels for the request and response words.
// Depends on nothing; used by the top level and its users.
`default_nettype none
interface acs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] address;
   logic [7:0] data;

   modport source (output valid, output mode, output address, output data, input ready);
   modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface acs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  accumulator;
   logic [7:0]  program_counter;
   logic        zero_flag;
   logic        negative_flag;
   logic        carry_flag;
   logic        halted;
   logic [15:0] step_count;

   modport source (output valid, output accumulator, output program_counter,
                   output zero_flag, output negative_flag, output carry_flag,
                   output halted, output step_count, input ready);
   modport sink   (input valid, input accumulator, input program_counter,
                   input zero_flag, input negative_flag, input carry_flag,
                   input halted, input step_count, output ready);
endinterface
`default_nettype wire

[rtl/accumulator_cpu_step_core.sv]
// Top level of the accumulator processor step core: microcode sequencer and datapath.
// Depends on acs_pkg, acs_req_if/acs_rsp_if and acs_mem.
//
//   channel | dir | word fields
//   req     | in  | mode, address, data
//   rsp     | out | accumulator, program_counter, zero/negative/carry flags, halted, step_count
//
// Load and restart run accept, own step, emit; an ignored mode runs accept, emit. Execute
// runs accept, fetch opcode, fetch operand, execute, emit; halted, accept, fetch opcode, emit.
// Opcode and operand come through the single registered memory read port, one after the other.
// Reset clears the step, the processor registers, the response valid and the memory valid bits,
// so memory reads zero until written. A stalled response holds in its register; the sequencer waits in its emit step.
`default_nettype none
module accumulator_cpu_step_core
   import acs_pkg::*;
#(
   parameter int MEM_DEPTH = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   acs_req_if.sink    req_port,
   acs_rsp_if.source  rsp_port
);
   step_type    step_ff, step_in;
   ctrl_type    ctrl;
   logic        req_fire;
   logic        out_free;

   logic [7:0]  addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  op_ff;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  pc_ff, pc_in;
   logic        zf_ff, zf_in;
   logic        nf_ff, nf_in;
   logic        cf_ff, cf_in;
   logic        halt_ff, halt_in;
   logic [15:0] cnt_ff, cnt_in;

   logic [7:0]  rd_addr;
   logic [7:0]  rd_data;
   logic [8:0]  sum9;
   logic [8:0]  diff9;
   logic [7:0]  pc_inc1;
   logic [7:0]  pc_inc2;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_acc_ff;
   logic [7:0]  rsp_pc_ff;
   logic        rsp_zf_ff;
   logic        rsp_nf_ff;
   logic        rsp_cf_ff;
   logic        rsp_halt_ff;
   logic [15:0] rsp_cnt_ff;

   assign ctrl     = ucode(step_ff);
   assign req_fire = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   assign req_port.ready = (ctrl.seq == SQ_ACCEPT);

   // next step
   always_comb begin
      step_in = step_ff;
      case (ctrl.seq)
         SQ_GO: step_in = ctrl.target;
         SQ_ACCEPT: begin
            if (req_fire) begin
               case (req_port.mode)
                  MODE_LOAD:    step_in = ST_LOAD;
                  MODE_EXEC:    step_in = ST_FETCH_OP;
                  MODE_RESTART: step_in = ST_RESTART;
                  default:      step_in = ST_EMIT;
               endcase
            end
         end
         SQ_HALTED:   step_in = halt_ff  ? ctrl.target : ctrl.alt;
         SQ_OUT_FREE: step_in = out_free ? ctrl.target : ctrl.alt;
         default:     step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // datapath
   assign pc_inc1 = pc_ff + 8'd1;
   assign pc_inc2 = pc_ff + 8'd2;
   assign rd_addr = ctrl.rd_next ? pc_inc1 : pc_ff;
   assign sum9    = {1'b0, acc_ff} + {1'b0, rd_data};
   assign diff9   = {1'b0, acc_ff} - {1'b0, rd_data};

   acs_mem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ctrl.mem_wr),
      .wr_addr (addr_ff),
      .wr_data (data_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      acc_in  = acc_ff;
      pc_in   = pc_ff;
      zf_in   = zf_ff;
      nf_in   = nf_ff;
      cf_in   = cf_ff;
      halt_in = halt_ff;
      cnt_in  = cnt_ff;
      if (ctrl.clr_regs) begin
         acc_in  = 8'h00;
         pc_in   = 8'h00;
         zf_in   = 1'b0;
         nf_in   = 1'b0;
         cf_in   = 1'b0;
         halt_in = 1'b0;
         cnt_in  = 16'h0000;
      end else if (ctrl.exec) begin
         if (cnt_ff != STEP_MAX) begin
            cnt_in = cnt_ff + 16'd1;
         end
         pc_in = pc_inc2;
         case (op_ff)
            OP_HLT: begin
               halt_in = 1'b1;
               pc_in   = pc_ff;
            end
            OP_LDA: acc_in = rd_data;
            OP_ADD: begin
               acc_in = sum9[7:0];
               cf_in  = sum9[8];
               nf_in  = 1'b0;
               zf_in  = (sum9[7:0] == 8'h00);
            end
            OP_SUB: begin
               acc_in = diff9[7:0];
               nf_in  = diff9[8];
               cf_in  = 1'b0;
               zf_in  = (diff9[7:0] == 8'h00);
            end
            OP_JMP: pc_in = rd_data;
            OP_JPZ: pc_in = zf_ff ? rd_data : pc_inc2;
            OP_JPN: pc_in = nf_ff ? rd_data : pc_inc2;
            OP_JPC: pc_in = cf_ff ? rd_data : pc_inc2;
            default: pc_in = pc_inc1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 8'h00;
         pc_ff   <= 8'h00;
         zf_ff   <= 1'b0;
         nf_ff   <= 1'b0;
         cf_ff   <= 1'b0;
         halt_ff <= 1'b0;
         cnt_ff  <= 16'h0000;
      end else begin
         acc_ff  <= acc_in;
         pc_ff   <= pc_in;
         zf_ff   <= zf_in;
         nf_ff   <= nf_in;
         cf_ff   <= cf_in;
         halt_ff <= halt_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff <= req_port.address;
         data_ff <= req_port.data;
      end
      if (ctrl.latch_op) begin
         op_ff <= rd_data;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && out_free) begin
         rsp_acc_ff  <= acc_ff;
         rsp_pc_ff   <= pc_ff;
         rsp_zf_ff   <= zf_ff;
         rsp_nf_ff   <= nf_ff;
         rsp_cf_ff   <= cf_ff;
         rsp_halt_ff <= halt_ff;
         rsp_cnt_ff  <= cnt_ff;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.accumulator     = rsp_acc_ff;
   assign rsp_port.program_counter = rsp_pc_ff;
   assign rsp_port.zero_flag       = rsp_zf_ff;
   assign rsp_port.negative_flag   = rsp_nf_ff;
   assign rsp_port.carry_flag      = rsp_cf_ff;
   assign rsp_port.halted          = rsp_halt_ff;
   assign rsp_port.step_count      = rsp_cnt_ff;
endmodule
`default_nettype wire

[rtl/acs_mem.sv]
// Program memory: single write port, one registered read port.
// Per-entry valid bits make unwritten and out-of-range bytes read as zero.
`default_nettype none
module acs_mem #(
   parameter int MEM_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [7:0] wr_addr,
   input  wire logic [7:0] wr_data,
   input  wire logic [7:0] rd_addr,
   output logic      [7:0] rd_data
);
   localparam int AW = $clog2(MEM_DEPTH);

   logic [7:0]           mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_ok_ff;
   logic                 wr_hit;
   logic                 rd_hit;

   assign wr_hit = wr_en && ({1'b0, wr_addr} < 9'(MEM_DEPTH));
   assign rd_hit = {1'b0, rd_addr} < 9'(MEM_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem_ff[wr_addr[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_hit) begin
            valid_ff[wr_addr[AW-1:0]] <= 1'b1;
         end
         rd_ok_ff <= rd_hit && valid_ff[rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : 8'h00;
endmodule
`default_nettype wire

[rtl/acs_checker.sv]
// Port-level checks for accumulator_cpu_step_core, attached by bind.
// Depends on the top level's ports only.
`default_nettype none
module acs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_accumulator,
   input wire logic        rsp_zero_flag,
   input wire logic        rsp_negative_flag,
   input wire logic        rsp_carry_flag,
   input wire logic        rsp_halted,
   input wire logic [15:0] rsp_step_count
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accumulator))
      else $error("response word dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_halt_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> rsp_step_count != 16'h0000)
      else $error("halted without any executed instruction");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_negative_flag && (rsp_zero_flag || rsp_carry_flag)))
      else $error("borrow flag set together with zero or carry");
endmodule

bind accumulator_cpu_step_core acs_checker u_acs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_accumulator   (rsp_port.accumulator),
   .rsp_zero_flag     (rsp_port.zero_flag),
   .rsp_negative_flag (rsp_port.negative_flag),
   .rsp_carry_flag    (rsp_port.carry_flag),
   .rsp_halted        (rsp_port.halted),
   .rsp_step_count    (rsp_port.step_count)
);
`default_nettype wire
